[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the hazard stall timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant violated");
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rhst_pkg.sv]
// Package for the hazard stall timer: constants, item types and helpers.
package rhst_pkg;

  localparam int NUM_REGS   = 32;
  localparam int REG_W      = 5;
  localparam int IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CYC_W      = 16;
  localparam int STALL_W    = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  localparam logic [CYC_W-1:0] CYC_MAX   = '1;
  localparam logic [CYC_W:0]   READY_LAT = (CYC_W+1)'(3);
  localparam logic [CYC_W:0]   WB_LAT    = (CYC_W+1)'(4);

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic             dest_used;
    logic [REG_W-1:0] dest_reg;
    logic             src_b_used;
    logic [REG_W-1:0] src_b;
    logic             src_a_used;
    logic [REG_W-1:0] src_a;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [CYC_W-1:0]   cycle_total;
    logic [CYC_W-1:0]   stall_total;
    logic [CYC_W-1:0]   hazard_total;
    logic               hazard_seen;
    logic [STALL_W-1:0] stall_cycles;
    logic [CYC_W-1:0]   fetch_cycle;
  } out_item_t;

  // Read request into the ready-cycle table
  typedef struct packed {
    logic             en;
    logic             use_a;
    logic [REG_W-1:0] reg_a;
    logic             use_b;
    logic [REG_W-1:0] reg_b;
  } tab_req_t;

  // Registered read response
  typedef struct packed {
    logic             ok_a;
    logic [CYC_W-1:0] val_a;
    logic             ok_b;
    logic [CYC_W-1:0] val_b;
  } tab_rd_t;

  // Write and clear from the timing stage
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CYC_W-1:0] data;
    logic             clr;
  } tab_wr_t;

  function automatic logic [CYC_W-1:0] sat16(input logic [CYC_W:0] v);
    return v[CYC_W] ? CYC_MAX : v[CYC_W-1:0];
  endfunction

  // Register numbers at or above NUM_REGS are not tracked
  function automatic logic in_table(input logic [REG_W-1:0] r);
    return int'(r) < NUM_REGS;
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [REG_W-1:0] r);
    return IDX_W'(r);
  endfunction

endpackage

[rtl/core/raw_hazard_stall_timer.sv]
// Top level: read-after-write stall timer for a pipeline without forwarding.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   s_tdata (instruction), s_tlast (end of trace)
//  m_*       out  m_tvalid/m_tready   m_tdata (timing result)
//
// One instruction per cycle sustained while the output is not stalled. The table is
// read in the accept cycle and the timing is computed in the next, from the
// registered read data; the result register follows.
// The previous-fetch recurrence is a combinational add and compare into prev_fetch.
// Synchronous reset clears handshake state, counters and table valid bits.
// A stalled output holds the result; one more instruction may be taken meanwhile.
module raw_hazard_stall_timer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // src_a[4:0], src_a_used[5], src_b[10:6], src_b_used[11], dest_reg[16:12],
  // dest_used[17], zero[23:18]
  input  logic [rhst_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fetch_cycle[15:0], stall_cycles[17:16], hazard_seen[18],
  // hazard_total[34:19], stall_total[50:35], cycle_total[66:51], zero[71:67]
  output logic [rhst_pkg::OUT_DATA_W-1:0]  m_tdata
);

`include "assert_macros.svh"

  localparam int CW = rhst_pkg::CYC_W;

  logic                 accept;
  logic                 adv;
  logic                 s1_valid;
  logic                 s1_last;
  rhst_pkg::in_item_t   s1_item;
  rhst_pkg::in_item_t   in_item;
  rhst_pkg::tab_req_t   req;
  rhst_pkg::tab_rd_t    rd;
  rhst_pkg::tab_wr_t    wr;
  rhst_pkg::out_item_t  out_q;
  rhst_pkg::out_item_t  res;

  logic [CW-1:0] prev_fetch;
  logic [CW-1:0] haz_cnt;
  logic [CW-1:0] stall_sum;
  logic [CW-1:0] haz_cnt_next;
  logic [CW-1:0] stall_sum_next;

  logic [CW-1:0] ra;
  logic [CW-1:0] rb;
  logic [CW-1:0] need;
  logic [CW:0]   init;
  logic [CW:0]   fetch_raw;
  logic [CW:0]   stall_full;
  logic          late;
  logic [rhst_pkg::STALL_W-1:0] stall;
  logic [CW-1:0] fetch;
  logic [CW-1:0] ready;

  // handshake
  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign accept   = s_tvalid && s_tready;
  assign in_item  = rhst_pkg::in_item_t'(s_tdata[$bits(rhst_pkg::in_item_t)-1:0]);

  // table read request at accept
  assign req.en    = accept;
  assign req.use_a = in_item.src_a_used;
  assign req.reg_a = in_item.src_a;
  assign req.use_b = in_item.src_b_used;
  assign req.reg_b = in_item.src_b;

  rhst_regtab u_regtab (
    .clk (clk),
    .rst (rst),
    .req (req),
    .wr  (wr),
    .rd  (rd)
  );

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
      s1_last <= s_tlast;
    end
  end

  // timing: fetch is one past the previous, pushed out to the latest ready source
  always_comb begin
    ra         = rd.ok_a ? rd.val_a : '0;
    rb         = rd.ok_b ? rd.val_b : '0;
    need       = (ra > rb) ? ra : rb;
    init       = {1'b0, prev_fetch} + (CW+1)'(1);
    late       = {1'b0, need} > init;
    fetch_raw  = late ? {1'b0, need} : init;
    stall_full = fetch_raw - init;
    stall      = rhst_pkg::STALL_W'(stall_full);
    fetch      = rhst_pkg::sat16(fetch_raw);
    ready      = rhst_pkg::sat16({1'b0, fetch} + rhst_pkg::READY_LAT);

    haz_cnt_next   = late ? rhst_pkg::sat16({1'b0, haz_cnt} + (CW+1)'(1))
                          : haz_cnt;
    stall_sum_next = rhst_pkg::sat16({1'b0, stall_sum} + (CW+1)'(stall));

    res.fetch_cycle  = fetch;
    res.stall_cycles = stall;
    res.hazard_seen  = late;
    res.hazard_total = haz_cnt_next;
    res.stall_total  = stall_sum_next;
    res.cycle_total  = rhst_pkg::sat16({1'b0, fetch} + rhst_pkg::WB_LAT);
  end

  // table update; end of trace clears every entry
  assign wr.en   = adv && s1_item.dest_used && rhst_pkg::in_table(s1_item.dest_reg);
  assign wr.addr = rhst_pkg::to_idx(s1_item.dest_reg);
  assign wr.data = ready;
  assign wr.clr  = adv && s1_last;

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_fetch <= '0;
      haz_cnt    <= '0;
      stall_sum  <= '0;
    end else if (adv) begin
      if (s1_last) begin
        prev_fetch <= '0;
        haz_cnt    <= '0;
        stall_sum  <= '0;
      end else begin
        prev_fetch <= fetch;
        haz_cnt    <= haz_cnt_next;
        stall_sum  <= stall_sum_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_tdata = rhst_pkg::OUT_DATA_W'(out_q);

  // checks
  `ASSERT_ALWAYS(a_stall_bound, clk, rst, !m_tvalid || (out_q.stall_cycles != 2'd3))
  `ASSERT_ALWAYS(a_hazard_flag, clk, rst, !m_tvalid || (out_q.hazard_seen == |out_q.stall_cycles))
  `ASSERT_ALWAYS(a_wb_after_fetch, clk, rst, !m_tvalid || (out_q.cycle_total >= out_q.fetch_cycle))
  `ASSERT_NEXT(a_result_follows, clk, rst, adv, m_tvalid)
  `ASSERT_NEXT(a_trace_clear, clk, rst, adv && s1_last, ~|{prev_fetch, haz_cnt, stall_sum})

endmodule

[rtl/core/rhst_regtab.sv]
// Ready-cycle table: one memory, two registered reads, write bypass, valid bits.
module rhst_regtab (
  input  logic              clk,
  input  logic              rst,
  input  rhst_pkg::tab_req_t req,
  input  rhst_pkg::tab_wr_t  wr,
  output rhst_pkg::tab_rd_t  rd
);

  logic [rhst_pkg::CYC_W-1:0]    mem [rhst_pkg::NUM_REGS];
  logic [rhst_pkg::NUM_REGS-1:0] vld;
  logic [rhst_pkg::IDX_W-1:0]    idx_a;
  logic [rhst_pkg::IDX_W-1:0]    idx_b;
  logic                          hit_a;
  logic                          hit_b;

  assign idx_a = rhst_pkg::to_idx(req.reg_a);
  assign idx_b = rhst_pkg::to_idx(req.reg_b);

  // a write landing this edge is forwarded to the read
  assign hit_a = wr.en && !wr.clr && (wr.addr == idx_a);
  assign hit_b = wr.en && !wr.clr && (wr.addr == idx_b);

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits; an entry not written since reset or the last clear reads as invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd.ok_a  <= req.use_a && rhst_pkg::in_table(req.reg_a) && !wr.clr &&
                  (hit_a || vld[idx_a]);
      rd.val_a <= hit_a ? wr.data : mem[idx_a];
      rd.ok_b  <= req.use_b && rhst_pkg::in_table(req.reg_b) && !wr.clr &&
                  (hit_b || vld[idx_b]);
      rd.val_b <= hit_b ? wr.data : mem[idx_b];
    end
  end

endmodule

[verif/raw_hazard_stall_timer_tb.sv]
// Self-checking testbench for the read-after-write stall timer.
`timescale 1ns / 100ps

module raw_hazard_stall_timer_tb;

  localparam int          IN_W        = rhst_pkg::IN_DATA_W;
  localparam int          IN_ITEM_W   = $bits(rhst_pkg::in_item_t);
  localparam int          RES_W       = $bits(rhst_pkg::out_item_t);
  localparam int unsigned CAP         = 65535;
  localparam int unsigned READY_DELAY = 3;
  localparam int unsigned WB_DELAY    = 4;
  localparam int unsigned RAND_ITEMS  = 1700;
  localparam int unsigned HOLD_CYCLES = 150;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [IN_W-1:0]                 s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [rhst_pkg::OUT_DATA_W-1:0] m_tdata;

  raw_hazard_stall_timer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Directed instruction with its timing typed in where it is obvious
  typedef struct packed {
    bit [4:0]  sa;
    bit        ua;
    bit [4:0]  sb;
    bit        ub;
    bit [4:0]  dr;
    bit        ud;
    bit        lst;
    bit        typed;
    bit [15:0] fc;
    bit [1:0]  st;
    bit [15:0] ht;
    bit [15:0] ss;
  } dir_row_t;

  //                sa ua sb ub dr ud lst typed fetch stall hz  stalls
  dir_row_t plan [0:21] = '{
    '{ 0, 0, 0, 0, 0, 0, 0, 1,  1, 0, 0, 0},  // nothing read or written
    '{ 0, 0, 0, 0, 0, 1, 0, 1,  2, 0, 0, 0},  // r0 written, ready at 5
    '{ 0, 1, 0, 0,31, 0, 0, 1,  5, 2, 1, 2},  // r0 read right away
    '{31, 0, 0, 1, 0, 0, 0, 1,  6, 0, 1, 2},  // r0 on b, already ready
    '{ 0, 0, 0, 0,31, 1, 0, 1,  7, 0, 1, 2},  // r31 ready at 10
    '{ 0, 0, 0, 0, 0, 0, 0, 1,  8, 0, 1, 2},
    '{31, 1, 0, 0, 0, 0, 0, 1, 10, 1, 2, 3},  // r31 read before it is ready
    '{ 0, 0, 0, 0, 5, 1, 0, 1, 11, 0, 2, 3},
    '{ 5, 1, 5, 1, 5, 1, 0, 1, 14, 2, 3, 5},  // reads r5 before rewriting it
    '{ 5, 0,31, 0, 5, 0, 0, 1, 15, 0, 3, 5},  // use flags low: no stall, no write
    '{ 5, 1, 0, 0, 0, 0, 0, 1, 17, 1, 4, 6},
    '{ 0, 0, 0, 0, 1, 1, 0, 1, 18, 0, 4, 6},
    '{ 0, 0, 0, 0, 2, 1, 0, 1, 19, 0, 4, 6},
    '{ 1, 1, 2, 1, 0, 0, 0, 1, 22, 2, 5, 8},  // later of two sources wins
    '{ 2, 1, 1, 1, 3, 1, 1, 1, 23, 0, 5, 8},  // end of trace
    '{ 3, 1, 0, 1, 0, 0, 0, 1,  1, 0, 0, 0},  // table cleared
    '{ 0, 0, 0, 0, 9, 1, 0, 1,  2, 0, 0, 0},
    '{ 9, 1, 9, 1, 0, 0, 1, 1,  5, 2, 1, 2},  // stalling last item
    '{31, 1,31, 1,31, 1, 1, 1,  1, 0, 0, 0},  // last right after last
    '{ 0, 0, 0, 0, 0, 0, 0, 1,  1, 0, 0, 0},
    '{ 7, 1, 0, 0, 7, 1, 0, 0,  0, 0, 0, 0},
    '{ 7, 1, 7, 1, 0, 0, 1, 0,  0, 0, 0, 0}
  };

  // Timing state of the pipeline being modeled
  logic [15:0] ready_at [rhst_pkg::NUM_REGS];
  logic [15:0] last_fetch;
  logic [15:0] hazard_cnt;
  logic [15:0] stall_acc;

  rhst_pkg::out_item_t timing_q [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_gap;
  int unsigned rx_hold_req;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned stalled_seen;
  int unsigned traces_run;
  int unsigned top_fetch;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned clip(input int unsigned v);
    return (v > CAP) ? CAP : v;
  endfunction

  function automatic void clear_timing();
    foreach (ready_at[i]) ready_at[i] = '0;
    last_fetch = '0;
    hazard_cnt = '0;
    stall_acc  = '0;
  endfunction

  // Fetch timing of one instruction; updates the table and the totals, clears them at end of trace
  function automatic rhst_pkg::out_item_t time_instr(input rhst_pkg::in_item_t ins,
                                                     input bit lst);
    rhst_pkg::out_item_t r;
    int unsigned start;
    int unsigned need;
    int unsigned slip;
    int unsigned fc;
    start = 32'(last_fetch) + 1;
    need  = 0;
    if (ins.src_a_used && int'(ins.src_a) < rhst_pkg::NUM_REGS &&
        ready_at[ins.src_a] > need)
      need = 32'(ready_at[ins.src_a]);
    if (ins.src_b_used && int'(ins.src_b) < rhst_pkg::NUM_REGS &&
        ready_at[ins.src_b] > need)
      need = 32'(ready_at[ins.src_b]);
    slip = (need > start) ? need - start : 0;
    fc   = clip(start + slip);
    if (slip != 0) begin
      hazard_cnt = 16'(clip(hazard_cnt + 1));
      stall_acc  = 16'(clip(stall_acc + slip));
    end
    // sources were checked first, so a self-write cannot stall itself
    if (ins.dest_used && int'(ins.dest_reg) < rhst_pkg::NUM_REGS)
      ready_at[ins.dest_reg] = 16'(clip(fc + READY_DELAY));
    last_fetch     = 16'(fc);
    r.fetch_cycle  = 16'(fc);
    r.stall_cycles = 2'(slip);
    r.hazard_seen  = (slip != 0);
    r.hazard_total = hazard_cnt;
    r.stall_total  = stall_acc;
    r.cycle_total  = 16'(clip(fc + WB_DELAY));
    if (lst) clear_timing();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Registers cluster around a small window so reads hit recent writes
  function automatic logic [4:0] pick_reg(input int unsigned base);
    if ($urandom_range(0, 3) != 0) return 5'(base + $urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic rhst_pkg::in_item_t make_instr(input bit noisy,
                                                    input int unsigned base);
    rhst_pkg::in_item_t ins;
    if (noisy) begin
      ins = IN_ITEM_W'($urandom);
    end else begin
      ins.src_a      = pick_reg(base);
      ins.src_a_used = ($urandom_range(0, 3) != 0);
      ins.src_b      = pick_reg(base);
      ins.src_b_used = ($urandom_range(0, 2) == 0);
      ins.dest_reg   = pick_reg(base);
      ins.dest_used  = ($urandom_range(0, 3) != 0);
    end
    return ins;
  endfunction

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d %s expected %0d got %0d",
                 $time, results_seen, fname, want, got);
    end
  endtask

  // Sender idles; data and last are scrambled while nothing is offered
  task automatic tx_gap(input int unsigned n);
    s_tvalid <= 1'b0;
    s_tdata  <= IN_W'($urandom);
    s_tlast  <= 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk);
  endtask

  // One instruction transfer; called and returns at a falling edge
  task automatic issue(input rhst_pkg::in_item_t ins, input bit lst, input bit typed,
                       input rhst_pkg::out_item_t fixed);
    rhst_pkg::out_item_t res;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) tx_gap(rand_gap());
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(ins);
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    res = time_instr(ins, lst);
    timing_q.push_back(typed ? fixed : res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (timing_q.size() != 0) @(negedge clk);
  endtask

  // One trace, well formed unless noisy; returns the number of instructions sent
  task automatic run_trace(input int unsigned len, input bit noisy,
                           output int unsigned sent);
    int unsigned        base;
    rhst_pkg::in_item_t ins;
    bit                 lst;
    base = $urandom_range(0, 28);
    for (int unsigned k = 0; k < len; k++) begin
      ins = make_instr(noisy, base);
      lst = noisy ? ($urandom_range(0, 7) == 0) : (k == len - 1);
      issue(ins, lst, 1'b0, '0);
    end
    traces_run++;
    sent = len;
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic squeeze(output int unsigned sent);
    tx_idle_pct = 0;
    rx_hold_req = HOLD_CYCLES;
    run_trace(40, 1'b0, sent);
  endtask

  // Result sink: random stalls plus requested long hold-offs
  always @(negedge clk) begin : sink
    if (rx_hold_req != 0) begin
      rx_gap      = rx_hold_req;
      rx_hold_req = 0;
    end else if (rx_gap == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap = rand_gap();
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    rhst_pkg::out_item_t seen;
    rhst_pkg::out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[RES_W-1:0];
      results_seen++;
      if (seen.hazard_seen) stalled_seen++;
      if (seen.fetch_cycle > top_fetch) top_fetch = 32'(seen.fetch_cycle);
      if (timing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with nothing pending (fetch %0d)",
                   $time, results_seen, seen.fetch_cycle);
      end else begin
        want = timing_q.pop_front();
        compare_field("fetch_cycle",  32'(want.fetch_cycle),  32'(seen.fetch_cycle));
        compare_field("stall_cycles", 32'(want.stall_cycles), 32'(seen.stall_cycles));
        compare_field("hazard_seen",  32'(want.hazard_seen),  32'(seen.hazard_seen));
        compare_field("hazard_total", 32'(want.hazard_total), 32'(seen.hazard_total));
        compare_field("stall_total",  32'(want.stall_total),  32'(seen.stall_total));
        compare_field("cycle_total",  32'(want.cycle_total),  32'(seen.cycle_total));
      end
    end
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    dir_row_t            row;
    rhst_pkg::in_item_t  ins;
    rhst_pkg::out_item_t fixed;
    int unsigned         rand_done;
    int unsigned         sent;
    int unsigned         len;
    bit                  noisy;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    rx_gap       = 0;
    rx_hold_req  = 0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    stalled_seen = 0;
    traces_run   = 0;
    top_fetch    = 0;
    rand_done    = 0;
    clear_timing();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    for (int i = 0; i < $size(plan); i++) begin
      row   = plan[i];
      ins   = '{dest_used: row.ud, dest_reg: row.dr, src_b_used: row.ub, src_b: row.sb,
                src_a_used: row.ua, src_a: row.sa};
      fixed = '{cycle_total: 16'(row.fc + WB_DELAY), stall_total: row.ss,
                hazard_total: row.ht, hazard_seen: (row.st != 0),
                stall_cycles: row.st, fetch_cycle: row.fc};
      issue(ins, row.lst, row.typed, fixed);
    end
    drain();

    // Long receiver hold-off with the sender pushing
    squeeze(sent);
    rand_done += sent;
    drain();

    // Random traces, mostly well formed, some noise
    while (rand_done < RAND_ITEMS) begin
      tx_idle_pct = pick_pct();
      rx_idle_pct = pick_pct();
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 40);
      noisy = ($urandom_range(0, 7) == 0);
      run_trace(len, noisy, sent);
      rand_done += sent;
      if (traces_run == 12 || traces_run == 45) begin
        squeeze(sent);
        rand_done += sent;
      end
      if (traces_run % 25 == 0) drain();
    end

    rx_idle_pct = 0;
    drain();
    repeat (8) @(posedge clk);

    if (timing_q.size() != 0) begin
      $display("%0d expected results never arrived", timing_q.size());
      mismatches += timing_q.size();
    end

    $display("Sent %0d instructions in %0d traces, %0d of them from the directed table,",
             items_sent, traces_run + 1, $size(plan));
    $display("  with long receiver stalls; checked %0d results, %0d stalled, top fetch %0d.",
             results_seen, stalled_seen, top_fetch);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
